// ===== rtl/cap_pkg.sv =====
// Package for the colour-aware parent selector: codes, config and stage types.
`timescale 1ns / 1ps
package cap_pkg;

  localparam int unsigned CostW  = 16;
  localparam int unsigned ColorW = 3;
  localparam int unsigned CfgIdxW = 3;

  localparam logic [CostW-1:0] COST_SAT = 16'hffff;

  // colour codes
  localparam logic [ColorW-1:0] COLOR_WHITE  = 3'd0;
  localparam logic [ColorW-1:0] COLOR_RED    = 3'd1;
  localparam logic [ColorW-1:0] COLOR_ORANGE = 3'd2;
  localparam logic [ColorW-1:0] COLOR_PURPLE = 3'd3;

  // metric type codes
  localparam logic [1:0] MT_ETX    = 2'd0;
  localparam logic [1:0] MT_LCOLOR = 2'd1;
  localparam logic [1:0] MT_ENERGY = 2'd2;
  localparam logic [1:0] MT_RANK   = 2'd3;

  // parent codes, shared by preferred_which and chosen
  localparam logic [1:0] PAR_NONE   = 2'd0;
  localparam logic [1:0] PAR_FIRST  = 2'd1;
  localparam logic [1:0] PAR_SECOND = 2'd2;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] REG_METRIC_TYPE   = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_OWN_COLOR     = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_ANCHOR_RANK   = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_MAX_LINK_COST = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_PATH_LIMIT    = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_SWITCH_THR    = 3'd5;

  // reset values
  localparam logic [1:0]        RST_METRIC_TYPE   = MT_LCOLOR;
  localparam logic [ColorW-1:0] RST_OWN_COLOR     = COLOR_WHITE;
  localparam logic [CostW-1:0]  RST_ANCHOR_RANK   = 16'd256;
  localparam logic [CostW-1:0]  RST_MAX_LINK_COST = 16'd1024;
  localparam logic [CostW-1:0]  RST_PATH_LIMIT    = 16'd32768;
  localparam logic [CostW-1:0]  RST_SWITCH_THR    = 16'd96;

  typedef struct packed {
    logic [1:0]        metric_type;
    logic [ColorW-1:0] own_color;
    logic [CostW-1:0]  anchor_rank;
    logic [CostW-1:0]  max_link_cost;
    logic [CostW-1:0]  path_limit;
    logic [CostW-1:0]  switch_threshold;
  } cfg_t;

  typedef struct packed {
    logic              present;
    logic [CostW-1:0]  link_cost;
    logic [CostW-1:0]  rank;
    logic [CostW-1:0]  metric;
    logic [ColorW-1:0] color;
  } cand_t;

  // after cost stage
  typedef struct packed {
    logic [CostW-1:0] c1;
    logic [CostW-1:0] c2;
    logic             link_ok1;
    logic             link_ok2;
    logic             root1;
    logic             root2;
    logic             red1;
    logic             red2;
    logic             orange1;
    logic             orange2;
    logic [1:0]       pref;
  } s1_t;

  // after compare stage
  typedef struct packed {
    logic             ok1;
    logic             ok2;
    logic [CostW-1:0] diff;
    logic             c1_lt;
    logic             root1;
    logic             root2;
    logic             red1;
    logic             red2;
    logic             orange1;
    logic             orange2;
    logic [1:0]       pref;
  } s2_t;

endpackage

// ===== rtl/cap_cost.sv =====
// Stage 1: path cost per candidate, link limit, root and colour decode.
`timescale 1ns / 1ps
module cap_cost (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_vld,
  input  cap_pkg::cfg_t cfg,
  input  cap_pkg::cand_t cand1,
  input  cap_pkg::cand_t cand2,
  input  logic [1:0]    pref,
  output logic          s1_vld,
  output cap_pkg::s1_t  s1
);

  logic         vld_r;
  cap_pkg::s1_t s1_r;
  cap_pkg::s1_t s1_nxt;

  function automatic logic [cap_pkg::CostW-1:0] route_cost(
    input logic [1:0]                mt,
    input logic [cap_pkg::CostW-1:0] link,
    input logic [cap_pkg::CostW-1:0] rank,
    input logic [cap_pkg::CostW-1:0] metric
  );
    logic [cap_pkg::CostW-1:0] base;
    logic [cap_pkg::CostW:0]   sum;
    case (mt)
      cap_pkg::MT_ETX, cap_pkg::MT_LCOLOR: base = metric;
      cap_pkg::MT_ENERGY: base = {metric[7:0], 8'h00};
      default: base = rank;
    endcase
    sum = {1'b0, base} + {1'b0, link};
    route_cost = sum[cap_pkg::CostW] ? cap_pkg::COST_SAT : sum[cap_pkg::CostW-1:0];
  endfunction

  always_comb begin
    s1_nxt.c1       = route_cost(cfg.metric_type, cand1.link_cost, cand1.rank, cand1.metric);
    s1_nxt.c2       = route_cost(cfg.metric_type, cand2.link_cost, cand2.rank, cand2.metric);
    s1_nxt.link_ok1 = cand1.present && (cand1.link_cost <= cfg.max_link_cost);
    s1_nxt.link_ok2 = cand2.present && (cand2.link_cost <= cfg.max_link_cost);
    s1_nxt.root1    = (cand1.rank == cfg.anchor_rank);
    s1_nxt.root2    = (cand2.rank == cfg.anchor_rank);
    s1_nxt.red1     = (cand1.color == cap_pkg::COLOR_RED);
    s1_nxt.red2     = (cand2.color == cap_pkg::COLOR_RED);
    s1_nxt.orange1  = (cand1.color == cap_pkg::COLOR_ORANGE);
    s1_nxt.orange2  = (cand2.color == cap_pkg::COLOR_ORANGE);
    s1_nxt.pref     = pref;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= in_vld;
    end
    s1_r <= s1_nxt;
  end

  assign s1_vld = vld_r;
  assign s1     = s1_r;

endmodule

// ===== rtl/cap_cmp.sv =====
// Stage 2: path cost limit, cost difference and cheaper-candidate flag.
`timescale 1ns / 1ps
module cap_cmp (
  input  logic          clk,
  input  logic          rst_n,
  input  cap_pkg::cfg_t cfg,
  input  logic          s1_vld,
  input  cap_pkg::s1_t  s1,
  output logic          s2_vld,
  output cap_pkg::s2_t  s2
);

  logic         vld_r;
  cap_pkg::s2_t s2_r;
  cap_pkg::s2_t s2_nxt;

  always_comb begin
    s2_nxt.ok1     = s1.link_ok1 && (s1.c1 <= cfg.path_limit);
    s2_nxt.ok2     = s1.link_ok2 && (s1.c2 <= cfg.path_limit);
    s2_nxt.c1_lt   = (s1.c1 < s1.c2);
    s2_nxt.diff    = s2_nxt.c1_lt ? (s1.c2 - s1.c1) : (s1.c1 - s1.c2);
    s2_nxt.root1   = s1.root1;
    s2_nxt.root2   = s1.root2;
    s2_nxt.red1    = s1.red1;
    s2_nxt.red2    = s1.red2;
    s2_nxt.orange1 = s1.orange1;
    s2_nxt.orange2 = s1.orange2;
    s2_nxt.pref    = s1.pref;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= s1_vld;
    end
    s2_r <= s2_nxt;
  end

  assign s2_vld = vld_r;
  assign s2     = s2_r;

endmodule

// ===== rtl/cap_pick.sv =====
// Stage 3: rule priority (eligibility, hysteresis, root, orange, own colour, cost).
`timescale 1ns / 1ps
module cap_pick (
  input  logic          clk,
  input  logic          rst_n,
  input  cap_pkg::cfg_t cfg,
  input  logic          s2_vld,
  input  cap_pkg::s2_t  s2,
  output logic          out_vld,
  output logic [1:0]    out_par
);

  logic       vld_r;
  logic [1:0] par_r;
  logic [1:0] par_nxt;
  logic [1:0] cheap;
  logic       pref_set;
  logic       own_red;
  logic       own_purple;

  always_comb begin
    cheap      = s2.c1_lt ? cap_pkg::PAR_FIRST : cap_pkg::PAR_SECOND;
    pref_set   = (s2.pref == cap_pkg::PAR_FIRST) || (s2.pref == cap_pkg::PAR_SECOND);
    own_red    = (cfg.own_color == cap_pkg::COLOR_RED);
    own_purple = (cfg.own_color == cap_pkg::COLOR_PURPLE);

    if (!s2.ok1) begin
      par_nxt = s2.ok2 ? cap_pkg::PAR_SECOND : cap_pkg::PAR_NONE;
    end else if (!s2.ok2) begin
      par_nxt = cap_pkg::PAR_FIRST;
    end else if ((s2.red1 == s2.red2) && pref_set && (s2.diff < cfg.switch_threshold)) begin
      par_nxt = s2.pref;
    end else if (s2.root1) begin
      par_nxt = cap_pkg::PAR_FIRST;
    end else if (s2.root2) begin
      par_nxt = cap_pkg::PAR_SECOND;
    end else if (s2.orange1) begin
      par_nxt = own_red ? cap_pkg::PAR_FIRST : cheap;
    end else if (s2.orange2) begin
      par_nxt = own_red ? cap_pkg::PAR_SECOND : cheap;
    end else if (own_purple) begin
      par_nxt = s2.red1 ? cap_pkg::PAR_FIRST : (s2.red2 ? cap_pkg::PAR_SECOND : cheap);
    end else if (own_red) begin
      // a lone red candidate wins; two or none fall back to cost
      if (s2.red1 && !s2.red2) begin
        par_nxt = cap_pkg::PAR_FIRST;
      end else if (s2.red2 && !s2.red1) begin
        par_nxt = cap_pkg::PAR_SECOND;
      end else begin
        par_nxt = cheap;
      end
    end else begin
      par_nxt = cheap;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= s2_vld;
    end
    par_r <= par_nxt;
  end

  assign out_vld = vld_r;
  assign out_par = par_r;

endmodule

// ===== rtl/color_aware_parent_select.sv =====
// Top level: config registers and the three-stage parent selection pipeline.
//
//   channel   ports                               handshake
//   input     start, busy, in_first_*, in_second_*, in_preferred_which
//                                                 taken when start & !busy
//   result    out_valid, out_chosen               one-cycle strobe, no back-pressure
//   config    cfg_we, cfg_idx, cfg_wdata          write when cfg_we high
//
// A transaction enters every cycle; its result strobe passes through the three register
// stages in order after acceptance: cost, compare, rule selection.
// busy is never raised: the receiver cannot stall, so nothing ever backs up.
// Synchronous active-low reset clears the stage valid bits and loads register defaults.
`timescale 1ns / 1ps
module color_aware_parent_select (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic                          in_first_present,
  input  logic [cap_pkg::CostW-1:0]     in_first_link_cost,
  input  logic [cap_pkg::CostW-1:0]     in_first_rank,
  input  logic [cap_pkg::CostW-1:0]     in_first_metric,
  input  logic [cap_pkg::ColorW-1:0]    in_first_color,
  input  logic                          in_second_present,
  input  logic [cap_pkg::CostW-1:0]     in_second_link_cost,
  input  logic [cap_pkg::CostW-1:0]     in_second_rank,
  input  logic [cap_pkg::CostW-1:0]     in_second_metric,
  input  logic [cap_pkg::ColorW-1:0]    in_second_color,
  input  logic [1:0]                    in_preferred_which,
  output logic                          out_valid,
  output logic [1:0]                    out_chosen,
  input  logic                          cfg_we,
  input  logic [cap_pkg::CfgIdxW-1:0]   cfg_idx,
  input  logic [cap_pkg::CostW-1:0]     cfg_wdata
);

  cap_pkg::cfg_t  cfg_r;
  cap_pkg::cand_t cand1;
  cap_pkg::cand_t cand2;
  cap_pkg::s1_t   s1;
  cap_pkg::s2_t   s2;
  logic           s1_vld;
  logic           s2_vld;
  logic           accept;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.metric_type      <= cap_pkg::RST_METRIC_TYPE;
      cfg_r.own_color        <= cap_pkg::RST_OWN_COLOR;
      cfg_r.anchor_rank      <= cap_pkg::RST_ANCHOR_RANK;
      cfg_r.max_link_cost    <= cap_pkg::RST_MAX_LINK_COST;
      cfg_r.path_limit       <= cap_pkg::RST_PATH_LIMIT;
      cfg_r.switch_threshold <= cap_pkg::RST_SWITCH_THR;
    end else if (cfg_we) begin
      case (cfg_idx)
        cap_pkg::REG_METRIC_TYPE:   cfg_r.metric_type      <= cfg_wdata[1:0];
        cap_pkg::REG_OWN_COLOR:     cfg_r.own_color        <= cfg_wdata[cap_pkg::ColorW-1:0];
        cap_pkg::REG_ANCHOR_RANK:   cfg_r.anchor_rank      <= cfg_wdata;
        cap_pkg::REG_MAX_LINK_COST: cfg_r.max_link_cost    <= cfg_wdata;
        cap_pkg::REG_PATH_LIMIT:    cfg_r.path_limit       <= cfg_wdata;
        cap_pkg::REG_SWITCH_THR:    cfg_r.switch_threshold <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    cand1.present   = in_first_present;
    cand1.link_cost = in_first_link_cost;
    cand1.rank      = in_first_rank;
    cand1.metric    = in_first_metric;
    cand1.color     = in_first_color;
    cand2.present   = in_second_present;
    cand2.link_cost = in_second_link_cost;
    cand2.rank      = in_second_rank;
    cand2.metric    = in_second_metric;
    cand2.color     = in_second_color;
  end

  cap_cost u_cost (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_vld (accept),
    .cfg    (cfg_r),
    .cand1  (cand1),
    .cand2  (cand2),
    .pref   (in_preferred_which),
    .s1_vld (s1_vld),
    .s1     (s1)
  );

  cap_cmp u_cmp (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg    (cfg_r),
    .s1_vld (s1_vld),
    .s1     (s1),
    .s2_vld (s2_vld),
    .s2     (s2)
  );

  cap_pick u_pick (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg_r),
    .s2_vld  (s2_vld),
    .s2      (s2),
    .out_vld (out_valid),
    .out_par (out_chosen)
  );

endmodule
